[rtl/fpsl_pkg.sv]
// shared types and constants for the passive serial configuration loader
`timescale 1ns / 1ps
package fpsl_pkg;

	localparam int CFG_W         = 20;
	localparam int CNT_W_DEFAULT = 20;
	localparam int BYTE_W        = 8;
	localparam int LAST_STEP     = 2 * BYTE_W;
	localparam int STEP_W        = $clog2(LAST_STEP + 1);
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [CFG_W-1:0] LOW_LIMIT_RST    = CFG_W'(100000);
	localparam logic [CFG_W-1:0] SETTLE_RST       = CFG_W'(100000);
	localparam logic [CFG_W-1:0] STATUS_LIMIT_RST = CFG_W'(3000);
	localparam logic [CFG_W-1:0] DONE_LIMIT_RST   = CFG_W'(1000000);

	localparam logic [1:0] REG_LOW_LIMIT    = 2'd0;
	localparam logic [1:0] REG_SETTLE       = 2'd1;
	localparam logic [1:0] REG_STATUS_LIMIT = 2'd2;
	localparam logic [1:0] REG_DONE_LIMIT   = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NOT_LOW  = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
	localparam logic [1:0] ERR_PHASE    = 2'd3;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_POLL  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_WAITLOW  = 3'd1,
		PH_SETTLE   = 3'd2,
		PH_WAITSTAT = 3'd3,
		PH_SHIFT    = 3'd4,
		PH_WAITDONE = 3'd5,
		PH_FINISHED = 3'd6
	} phase_t;

	typedef struct packed {
		logic              multi;
		logic [BYTE_W-1:0] byte_v;
		logic              nconfig;
		logic              data;
		phase_t            phase_a;
		phase_t            phase_b;
		logic              warning;
		logic [1:0]        err;
	} job_t;

endpackage

[rtl/fpsl_front.sv]
// front end: config registers, sequence state and job classification
`timescale 1ns / 1ps
module fpsl_front
	import fpsl_pkg::*;
#(
	parameter int COUNTER_WIDTH = CNT_W_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              accept,
	input  logic [1:0]        action,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  logic              conf_done_pin,
	input  logic              nstatus_pin,
	input  logic              nconfig_readback,
	output job_t              job
);

	localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

	logic [CFG_W-1:0]         low_lim_q, settle_q, stat_lim_q, done_lim_q;
	phase_t                   phase_q, nxt_phase;
	logic [COUNTER_WIDTH-1:0] cnt_q, nxt_cnt, cnt_inc;
	logic                     data_q, nxt_data;
	logic                     cfg_lvl_q, nxt_cfg_lvl;
	logic                     warn_q, nxt_warn;
	logic [1:0]               err_q, nxt_err;
	action_t                  act;
	logic [CMP_W-1:0]         inc_ext;
	logic [CFG_W-1:0]         lim_low, lim_stat, lim_done;

	function automatic logic [CFG_W-1:0] eff_limit(input logic [CFG_W-1:0] lim);
		eff_limit = (lim == '0) ? CFG_W'(1) : lim;
	endfunction

	assign act      = action_t'(action);
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign inc_ext  = CMP_W'(cnt_inc);
	assign lim_low  = eff_limit(low_lim_q);
	assign lim_stat = eff_limit(stat_lim_q);
	assign lim_done = eff_limit(done_lim_q);

	always_comb begin
		nxt_phase   = phase_q;
		nxt_cnt     = cnt_q;
		nxt_data    = data_q;
		nxt_cfg_lvl = cfg_lvl_q;
		nxt_warn    = warn_q;
		nxt_err     = err_q;
		job.multi   = 1'b0;
		job.byte_v  = data_byte;
		unique case (act)
			ACT_START: begin
				nxt_cfg_lvl = 1'b0;
				nxt_data    = 1'b0;
				nxt_cnt     = '0;
				nxt_warn    = 1'b0;
				nxt_err     = ERR_NONE;
				nxt_phase   = PH_WAITLOW;
			end
			ACT_BYTE: begin
				if (phase_q == PH_SHIFT) begin
					job.multi = 1'b1;
					nxt_data  = data_byte[BYTE_W-1];
					if (last_byte) begin
						nxt_cnt   = '0;
						nxt_phase = PH_WAITDONE;
					end
				end
			end
			ACT_POLL: begin
				case (phase_q)
					PH_WAITLOW: begin
						if (!nconfig_readback && !conf_done_pin) begin
							nxt_cfg_lvl = 1'b1;
							nxt_cnt     = '0;
							nxt_phase   = (settle_q == '0) ? PH_WAITSTAT : PH_SETTLE;
						end else begin
							nxt_cnt = cnt_inc;
							if (inc_ext >= CMP_W'(lim_low)) begin
								nxt_err   = ERR_NOT_LOW;
								nxt_phase = PH_IDLE;
							end
						end
					end
					PH_SETTLE: begin
						nxt_cnt = cnt_inc;
						if (inc_ext >= CMP_W'(settle_q)) begin
							nxt_cnt   = '0;
							nxt_phase = PH_WAITSTAT;
						end
					end
					PH_WAITSTAT: begin
						if (nstatus_pin) begin
							nxt_cnt   = '0;
							nxt_phase = PH_SHIFT;
						end else begin
							nxt_cnt = cnt_inc;
							if (inc_ext >= CMP_W'(lim_stat)) begin
								nxt_warn  = 1'b1;
								nxt_cnt   = '0;
								nxt_phase = PH_SHIFT;
							end
						end
					end
					PH_WAITDONE: begin
						if (conf_done_pin && nstatus_pin) begin
							nxt_cnt   = '0;
							nxt_phase = PH_FINISHED;
						end else begin
							nxt_cnt = cnt_inc;
							if (inc_ext >= CMP_W'(lim_done)) begin
								nxt_err   = ERR_TIMEOUT;
								nxt_phase = PH_IDLE;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ACT_NOP: begin
			end
		endcase
		job.nconfig = nxt_cfg_lvl;
		job.data    = nxt_data;
		job.phase_a = phase_q;
		job.phase_b = nxt_phase;
		job.warning = nxt_warn;
		job.err     = (act == ACT_BYTE && phase_q != PH_SHIFT) ? ERR_PHASE : nxt_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_lim_q  <= LOW_LIMIT_RST;
			settle_q   <= SETTLE_RST;
			stat_lim_q <= STATUS_LIMIT_RST;
			done_lim_q <= DONE_LIMIT_RST;
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			data_q     <= 1'b0;
			cfg_lvl_q  <= 1'b1;
			warn_q     <= 1'b0;
			err_q      <= ERR_NONE;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_LOW_LIMIT:    low_lim_q  <= cfg_data;
					REG_SETTLE:       settle_q   <= cfg_data;
					REG_STATUS_LIMIT: stat_lim_q <= cfg_data;
					REG_DONE_LIMIT:   done_lim_q <= cfg_data;
				endcase
			end
			if (accept) begin
				phase_q   <= nxt_phase;
				cnt_q     <= nxt_cnt;
				data_q    <= nxt_data;
				cfg_lvl_q <= nxt_cfg_lvl;
				warn_q    <= nxt_warn;
				err_q     <= nxt_err;
			end
		end
	end

endmodule

[rtl/fpsl_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps
module fpsl_queue
	import fpsl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fpsl_back.sv]
// back end: expands jobs into pin beats
`timescale 1ns / 1ps
module fpsl_back
	import fpsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_avail,
	input  job_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       nconfig_drive,
	output logic       data_drive,
	output logic       dclk_drive,
	output logic [2:0] phase_now,
	output logic       status_warning,
	output logic [1:0] error_code,
	output logic       last_of_run
);

	job_t              cur_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              at_end, beat_done;

	assign at_end    = (step_q == STEP_W'(LAST_STEP));
	assign last_of_run = !cur_q.multi || at_end;
	assign out_valid = busy_q;
	assign beat_done = busy_q && !out_stall;
	assign q_pop     = q_avail && (!busy_q || (beat_done && last_of_run));

	assign nconfig_drive  = cur_q.nconfig;
	assign dclk_drive     = cur_q.multi && step_q[0];
	assign status_warning = cur_q.warning;
	assign error_code     = cur_q.err;
	assign phase_now      = (cur_q.multi && !at_end) ? cur_q.phase_a : cur_q.phase_b;

	always_comb begin
		if (!cur_q.multi) begin
			data_drive = cur_q.data;
		end else if (at_end) begin
			data_drive = cur_q.byte_v[BYTE_W-1];
		end else begin
			data_drive = cur_q.byte_v[step_q[$clog2(BYTE_W):1]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (beat_done && last_of_run) begin
				busy_q <= 1'b0;
			end else if (beat_done) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

[rtl/fpga_passive_serial_loader.sv]
// top level of the passive serial configuration loader
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    action, data_byte, last_byte, pin samples
//  out      source     out_valid / out_stall  pin drives, phase, warning, error, last
//  cfg      sink       cfg_write              cfg_index, cfg_data
//
// start, poll and idle items give one out beat each and can enter every cycle while
// the 4-entry job queue has room. a data byte in the shift phase gives 17 out beats,
// one a cycle from the back end while out_stall is low, and takes one queue slot.
// in_stall rises only while that queue is full; out_stall freezes the back end alone.
// arst_n clears the sequence state and loads the default limits.
`timescale 1ns / 1ps
module fpga_passive_serial_loader
	import fpsl_pkg::*;
#(
	parameter int COUNTER_WIDTH = CNT_W_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  logic              conf_done_pin,
	input  logic              nstatus_pin,
	input  logic              nconfig_readback,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              nconfig_drive,
	output logic              data_drive,
	output logic              dclk_drive,
	output logic [2:0]        phase_now,
	output logic              status_warning,
	output logic [1:0]        error_code,
	output logic              last_of_run
);

	logic accept, q_full, q_avail, q_pop;
	job_t new_job, q_head;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	fpsl_front #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.accept           (accept),
		.action           (action),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.conf_done_pin    (conf_done_pin),
		.nstatus_pin      (nstatus_pin),
		.nconfig_readback (nconfig_readback),
		.job              (new_job)
	);

	fpsl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (new_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	fpsl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_avail        (q_avail),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.nconfig_drive  (nconfig_drive),
		.data_drive     (data_drive),
		.dclk_drive     (dclk_drive),
		.phase_now      (phase_now),
		.status_warning (status_warning),
		.error_code     (error_code),
		.last_of_run    (last_of_run)
	);

endmodule

[tb/tb_fpga_passive_serial_loader.sv]
// testbench for the passive serial configuration loader with predictor and scoreboard
`timescale 1ns / 1ps
module tb_fpga_passive_serial_loader;
	import fpsl_pkg::*;

	localparam logic [CNT_W_DEFAULT-1:0] CNT_TOP = {CNT_W_DEFAULT{1'b1}};
	localparam logic [CFG_W-1:0] LIMIT_MAX = {CFG_W{1'b1}};
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		action_t           act;
		logic [BYTE_W-1:0] dbyte;
		logic              last;
		logic              done;
		logic              nstat;
		logic              rback;
	} load_item_t;

	typedef struct packed {
		logic       nconfig;
		logic       data;
		logic       dclk;
		logic [2:0] phase;
		logic       warning;
		logic [1:0] err;
		logic       last;
	} pin_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        action = '0;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              last_byte = 1'b0;
	logic              conf_done_pin = 1'b0;
	logic              nstatus_pin = 1'b0;
	logic              nconfig_readback = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              nconfig_drive;
	logic              data_drive;
	logic              dclk_drive;
	logic [2:0]        phase_now;
	logic              status_warning;
	logic [1:0]        error_code;
	logic              last_of_run;

	fpga_passive_serial_loader dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.conf_done_pin    (conf_done_pin),
		.nstatus_pin      (nstatus_pin),
		.nconfig_readback (nconfig_readback),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.nconfig_drive    (nconfig_drive),
		.data_drive       (data_drive),
		.dclk_drive       (dclk_drive),
		.phase_now        (phase_now),
		.status_warning   (status_warning),
		.error_code       (error_code),
		.last_of_run      (last_of_run)
	);

	load_item_t load_q[$];
	pin_beat_t  pin_beats_due[$];
	int         mismatches = 0;
	int         made = 0;
	int         tx_gap = 0;
	int         rx_wait = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	bit         hold_rx = 1'b0;
	bit         press_go = 1'b0;
	logic [CFG_W-1:0] settle_pick;

	// predictor copy of limits and sequence state
	logic [CFG_W-1:0]         lim_low = LOW_LIMIT_RST;
	logic [CFG_W-1:0]         lim_settle = SETTLE_RST;
	logic [CFG_W-1:0]         lim_status = STATUS_LIMIT_RST;
	logic [CFG_W-1:0]         lim_done = DONE_LIMIT_RST;
	phase_t                   pr_phase = PH_IDLE;
	logic [CNT_W_DEFAULT-1:0] pr_cnt = '0;
	logic                     pr_data = 1'b0;
	logic                     pr_ncfg = 1'b1;
	logic                     pr_warn = 1'b0;
	logic [1:0]               pr_err = ERR_NONE;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int draw_wait(bit calm);
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	task automatic apply_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_LOW_LIMIT: lim_low = v;
			REG_SETTLE: lim_settle = v;
			REG_STATUS_LIMIT: lim_status = v;
			REG_DONE_LIMIT: lim_done = v;
			default: ;
		endcase
	endtask

	function automatic logic poll_gives_up(logic [CFG_W-1:0] limit);
		if (pr_cnt != CNT_TOP)
			pr_cnt = pr_cnt + 1'b1;
		return pr_cnt >= ((limit == '0) ? CFG_W'(1) : limit);
	endfunction

	task automatic expect_beat(logic d, logic ck, logic [1:0] e, logic l);
		pin_beat_t b;
		b.nconfig = pr_ncfg;
		b.data = d;
		b.dclk = ck;
		b.phase = pr_phase;
		b.warning = pr_warn;
		b.err = e;
		b.last = l;
		pin_beats_due.push_back(b);
	endtask

	task automatic predict_pins(action_t a, logic [BYTE_W-1:0] d, logic l,
			logic done, logic nstat, logic rback);
		case (a)
			ACT_START: begin
				pr_ncfg = 1'b0;
				pr_data = 1'b0;
				pr_cnt = '0;
				pr_warn = 1'b0;
				pr_err = ERR_NONE;
				pr_phase = PH_WAITLOW;
				expect_beat(pr_data, 1'b0, pr_err, 1'b1);
			end
			ACT_BYTE: begin
				if (pr_phase != PH_SHIFT) begin
					expect_beat(pr_data, 1'b0, ERR_PHASE, 1'b1);
				end else begin
					for (int b = 0; b < BYTE_W; b++) begin
						pr_data = d[b];
						expect_beat(pr_data, 1'b0, pr_err, 1'b0);
						expect_beat(pr_data, 1'b1, pr_err, 1'b0);
					end
					if (l) begin
						pr_cnt = '0;
						pr_phase = PH_WAITDONE;
					end
					expect_beat(pr_data, 1'b0, pr_err, 1'b1);
				end
			end
			ACT_POLL: begin
				case (pr_phase)
					PH_WAITLOW: begin
						if (!rback && !done) begin
							pr_ncfg = 1'b1;
							pr_cnt = '0;
							pr_phase = (lim_settle == '0) ? PH_WAITSTAT : PH_SETTLE;
						end else if (poll_gives_up(lim_low)) begin
							pr_err = ERR_NOT_LOW;
							pr_phase = PH_IDLE;
						end
					end
					PH_SETTLE: begin
						if (pr_cnt != CNT_TOP)
							pr_cnt = pr_cnt + 1'b1;
						if (pr_cnt >= lim_settle) begin
							pr_cnt = '0;
							pr_phase = PH_WAITSTAT;
						end
					end
					PH_WAITSTAT: begin
						if (nstat) begin
							pr_cnt = '0;
							pr_phase = PH_SHIFT;
						end else if (poll_gives_up(lim_status)) begin
							pr_warn = 1'b1;
							pr_cnt = '0;
							pr_phase = PH_SHIFT;
						end
					end
					PH_WAITDONE: begin
						if (done && nstat) begin
							pr_cnt = '0;
							pr_phase = PH_FINISHED;
						end else if (poll_gives_up(lim_done)) begin
							pr_err = ERR_TIMEOUT;
							pr_phase = PH_IDLE;
						end
					end
					default: ;
				endcase
				expect_beat(pr_data, 1'b0, pr_err, 1'b1);
			end
			default: expect_beat(pr_data, 1'b0, pr_err, 1'b1);
		endcase
	endtask

	task automatic flag_beat(string why, pin_beat_t want, pin_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s exp: ncfg=%b data=%b dclk=%b ph=%0d warn=%b err=%0d last=%b", why,
				want.nconfig, want.data, want.dclk, want.phase, want.warning, want.err,
				want.last);
			$display("%s got: ncfg=%b data=%b dclk=%b ph=%0d warn=%b err=%0d last=%b", why,
				got.nconfig, got.data, got.dclk, got.phase, got.warning, got.err, got.last);
		end
	endtask

	// sender
	always @(posedge clk) begin : feed
		load_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (load_q.size() != 0) begin
				it = load_q.pop_front();
				action <= it.act;
				data_byte <= it.dbyte;
				last_byte <= it.last;
				conf_done_pin <= it.done;
				nstatus_pin <= it.nstat;
				nconfig_readback <= it.rback;
				in_valid <= 1'b1;
				if ($urandom_range(0, 29) == 0)
					tx_calm = !tx_calm;
				tx_gap <= draw_wait(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			rx_wait = draw_wait(rx_calm);
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
		end
		out_stall <= hold_rx || (rx_wait > 0);
	end

	// long receiver hold-off once bytes start flowing
	initial begin
		wait (press_go && pr_phase == PH_SHIFT);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin : watch
		pin_beat_t got;
		pin_beat_t want;
		if (arst_n) begin
			if (cfg_write)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				predict_pins(action_t'(action), data_byte, last_byte, conf_done_pin,
					nstatus_pin, nconfig_readback);
			if (out_valid && !out_stall) begin
				got.nconfig = nconfig_drive;
				got.data = data_drive;
				got.dclk = dclk_drive;
				got.phase = phase_now;
				got.warning = status_warning;
				got.err = error_code;
				got.last = last_of_run;
				if (pin_beats_due.size() == 0) begin
					flag_beat("unexpected beat", '0, got);
				end else begin
					want = pin_beats_due.pop_front();
					if (got !== want)
						flag_beat("beat mismatch", want, got);
				end
			end
		end
	end

	task automatic queue_item(action_t a, logic [BYTE_W-1:0] d, logic l,
			logic done, logic nstat, logic rback);
		load_item_t it;
		it.act = a;
		it.dbyte = d;
		it.last = l;
		it.done = done;
		it.nstat = nstat;
		it.rback = rback;
		load_q.push_back(it);
		made++;
	endtask

	task automatic queue_poll(logic done, logic nstat, logic rback);
		queue_item(ACT_POLL, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			done, nstat, rback);
	endtask

	task automatic queue_data(logic [BYTE_W-1:0] d, logic l);
		queue_item(ACT_BYTE, d, l, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic queue_noise();
		queue_item(action_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] st,
			logic [CFG_W-1:0] ns, logic [CFG_W-1:0] dn);
		write_reg(REG_LOW_LIMIT, lo);
		write_reg(REG_SETTLE, st);
		write_reg(REG_STATUS_LIMIT, ns);
		write_reg(REG_DONE_LIMIT, dn);
		settle_pick = st;
	endtask

	function automatic logic [CFG_W-1:0] draw_limit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LIMIT_MAX;
			2: return CFG_W'(1);
			default: return CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic drain();
		do @(negedge clk);
		while (load_q.size() != 0 || in_valid || pin_beats_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// one load attempt after a start: pin polls and a short image, with random slips
	task automatic queue_load();
		int n;
		int pick;
		repeat ($urandom_range(0, 3)) begin
			pick = $urandom_range(1, 3);
			queue_poll(pick[1], 1'($urandom_range(0, 1)), pick[0]);
		end
		queue_poll(1'b0, 1'($urandom_range(0, 1)), 1'b0);
		repeat ((settle_pick <= 8) ? int'(settle_pick) : int'($urandom_range(0, 3)))
			queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 3))
			queue_poll(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
		queue_poll(1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_noise();
			queue_data(BYTE_W'($urandom_range(0, 255)), i == n - 1);
		end
		repeat ($urandom_range(0, 3)) begin
			pick = $urandom_range(0, 2);
			queue_poll(pick[1], pick[0], 1'($urandom_range(0, 1)));
		end
		queue_poll(1'b1, 1'b1, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			queue_data(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		int target;
		int p;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		settle_pick = SETTLE_RST;
		@(negedge clk);

		// default limits: idle items, byte out of phase, abort during settle
		queue_poll(1'b1, 1'b1, 1'b1);
		queue_item(ACT_NOP, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_data(8'hFF, 1'b1);
		queue_item(ACT_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
		queue_poll(1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b1, 1'b0);
		drain();

		// wait-low timeout, zero settle, zero status limit, done timeout
		set_limits(CFG_W'(2), '0, '0, CFG_W'(1));
		queue_item(ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b0, 1'b1);
		queue_poll(1'b1, 1'b0, 1'b0);
		queue_item(ACT_START, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b0, 1'b0);
		queue_data(8'h00, 1'b0);
		queue_data(8'hFF, 1'b1);
		queue_poll(1'b0, 1'b1, 1'b0);
		queue_data(8'h5A, 1'b0);
		queue_item(ACT_NOP, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
		drain();

		// zero low limit, full-range status and done limits, clean finish
		set_limits('0, CFG_W'(1), LIMIT_MAX, LIMIT_MAX);
		queue_item(ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b0, 1'b1);
		queue_item(ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_poll(1'b0, 1'b1, 1'b0);
		queue_poll(1'b1, 1'b0, 1'b1);
		queue_poll(1'b0, 1'b1, 1'b1);
		queue_data(8'hA5, 1'b1);
		queue_poll(1'b1, 1'b0, 1'b0);
		queue_poll(1'b1, 1'b1, 1'b0);
		queue_poll(1'b0, 1'b0, 1'b0);
		drain();

		made = 0;
		p = 0;
		while (made < RANDOM_ITEMS) begin
			if (p == 2) begin
				set_limits(CFG_W'(4), CFG_W'(2), CFG_W'(4), CFG_W'(8));
				press_go = 1'b1;
				queue_item(ACT_START, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
				queue_poll(1'b0, 1'b0, 1'b0);
				queue_poll(1'b0, 1'b0, 1'b0);
				queue_poll(1'b0, 1'b0, 1'b0);
				queue_poll(1'b0, 1'b1, 1'b0);
				for (int i = 0; i < 12; i++)
					queue_data(BYTE_W'($urandom_range(0, 255)), i == 11);
				queue_poll(1'b1, 1'b1, 1'b0);
			end else begin
				set_limits(draw_limit(), draw_limit(), draw_limit(), draw_limit());
				target = (made + 70 < RANDOM_ITEMS) ? made + 70 : RANDOM_ITEMS;
				while (made < target) begin
					if ($urandom_range(0, 7) == 0) begin
						repeat ($urandom_range(3, 10)) queue_noise();
					end else begin
						queue_item(ACT_START, BYTE_W'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						queue_load();
					end
				end
			end
			drain();
			p++;
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && pin_beats_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
